@@ design/sliding_window_slot_tracker_assert.svh @@
// ----------------------------------------------------------------------------
// Sliding window slot tracker assertion macros
// Shorthand for the clocked, reset-qualified properties of the checker.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_SLOT_TRACKER_ASSERT_SVH
`define SLIDING_WINDOW_SLOT_TRACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWST_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sliding window slot tracker check failed");

// The consequent must hold in the cycle after the antecedent.
`define SWST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sliding window slot tracker check failed");

`endif

@@ design/swst_pkg.sv @@
// ----------------------------------------------------------------------------
// Sliding window slot tracker package
// Widths, operation and status codes, sequencer states and shared helpers.
// ----------------------------------------------------------------------------
package swst_pkg;

    localparam int MAX_SLOTS  = 1024;
    localparam int SEQ_W      = 32;
    localparam int LEN_W      = 11;
    localparam int CFG_W      = 11;
    localparam int OFF_W      = 11;
    localparam int COUNT_W    = 11;
    localparam int COUNT_MAX  = 1024;
    localparam int OFFSET_MAX = 1024;
    localparam int WS_RESET   = 8;

    // Largest window that is honored: bounded by the count limit and the slot store.
    localparam int SIZE_MAX = (COUNT_MAX < MAX_SLOTS) ? COUNT_MAX : MAX_SLOTS;
    localparam int SLOT_W   = $clog2(MAX_SLOTS);
    localparam int EFF_W    = $clog2(SIZE_MAX + 1);
    localparam int STEP_W   = $clog2(SEQ_W + 1);
    localparam int ENTRY_W  = 1 + SEQ_W + LEN_W;

    typedef enum logic [2:0] {
        OP_STORE   = 3'd0,
        OP_DELETE  = 3'd1,
        OP_SLIDE   = 3'd2,
        OP_ADVANCE = 3'd3,
        OP_LOOKUP  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_CONFLICT = 2'd1,
        STAT_MISMATCH = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_CHECK,
        S_SLIDE_RD,
        S_SLIDE_CHK,
        S_SLIDE_FIN,
        S_ADVANCE,
        S_RESP
    } state_t;

    typedef struct packed {
        logic              valid;
        logic [SEQ_W-1:0]  seq;
        logic [LEN_W-1:0]  length;
    } entry_t;

    typedef struct packed {
        logic              busy;
        logic [SLOT_W-1:0] remainder;
    } rem_stat_t;

    function automatic logic [EFF_W-1:0] eff_size(input logic [CFG_W-1:0] ws);
        logic [EFF_W-1:0] eff;
        if (ws == '0) begin
            eff = EFF_W'(1);
        end
        else if (ws > CFG_W'(SIZE_MAX)) begin
            eff = EFF_W'(SIZE_MAX);
        end
        else begin
            eff = EFF_W'(ws);
        end
        return eff;
    endfunction

    // Serial-number ordering: a lies below b when a - b is negative.
    function automatic logic serial_below(input logic [SEQ_W-1:0] a,
                                          input logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] diff;
        diff = a - b;
        return diff[SEQ_W-1];
    endfunction

endpackage

@@ design/swst_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module swst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/swst_rem_unit.sv @@
// ----------------------------------------------------------------------------
// Sliding window slot tracker remainder unit
// Restoring remainder of a sequence number by the window size, one bit a cycle.
// ----------------------------------------------------------------------------
module swst_rem_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [swst_pkg::SEQ_W-1:0]    dividend,
    input  logic [swst_pkg::EFF_W-1:0]    divisor,
    output swst_pkg::rem_stat_t           stat
);

    logic [swst_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic [swst_pkg::SEQ_W-1:0]  dvd_reg, dvd_next;
    logic [swst_pkg::EFF_W-1:0]  div_reg, div_next;
    logic [swst_pkg::SLOT_W-1:0] rem_reg, rem_next;
    logic [swst_pkg::SLOT_W:0]   trial;
    logic [swst_pkg::SLOT_W:0]   div_ext;

    always_comb
    begin
        cnt_next = cnt_reg;
        dvd_next = dvd_reg;
        div_next = div_reg;
        rem_next = rem_reg;
        trial    = {rem_reg, dvd_reg[swst_pkg::SEQ_W-1]};
        div_ext  = (swst_pkg::SLOT_W + 1)'(div_reg);
        if (start)
        begin
            cnt_next = swst_pkg::STEP_W'(swst_pkg::SEQ_W);
            dvd_next = dividend;
            div_next = divisor;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            // The partial remainder stays below the divisor, so it fits the slot index.
            if (trial >= div_ext)
            begin
                rem_next = swst_pkg::SLOT_W'(trial - div_ext);
            end
            else
            begin
                rem_next = trial[swst_pkg::SLOT_W-1:0];
            end
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign stat.busy      = (cnt_reg != '0);
    assign stat.remainder = rem_reg;

endmodule

@@ design/sliding_window_slot_tracker.sv @@
// ----------------------------------------------------------------------------
// Sliding window slot tracker
// Slot bookkeeping for a selective-repeat sender window.
// ----------------------------------------------------------------------------
// A request word (op, seq, length, offset) is taken when req_valid is high and
// req_stall is low; each request gives exactly one response word on the rsp
// channel, held until rsp_stall is low. The window size register is written
// through cfg_valid/cfg_ready/cfg_data; the user must do so only while no
// request is in flight, and the block does not enforce it. Slot index = seq
// mod window size, worked out by a shared remainder unit one dividend bit per
// cycle; store, delete and look up then read and check the slot. A slide makes
// one RAM read and one check/clear step for every sequence number passed,
// through the single slot RAM port pair.
// One request is worked on at a time; req_stall is high while it is busy, and
// the next request is taken in the cycle after a response word is loaded.
// A finished response sits in the output register, and the next request is
// taken while it waits; that request's response waits if rsp_stall stays high.
// After reset the block clears the valid bits of all 1024 slots, one per
// cycle, and holds req_stall high while it does so. The window size resets
// to 8 and the lower edge, current pointer and item count to zero.
// ----------------------------------------------------------------------------
module sliding_window_slot_tracker (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [swst_pkg::CFG_W-1:0]    cfg_data,

    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [2:0]                    op,
    input  logic [swst_pkg::SEQ_W-1:0]    seq,
    input  logic [swst_pkg::LEN_W-1:0]    length,
    input  logic [swst_pkg::OFF_W-1:0]    offset,

    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [1:0]                    status,
    output logic                          found,
    output logic [swst_pkg::LEN_W-1:0]    stored_length,
    output logic [swst_pkg::COUNT_W-1:0]  num_items,
    output logic [swst_pkg::SEQ_W-1:0]    lower_edge,
    output logic [swst_pkg::SEQ_W-1:0]    current_seq,
    output logic [swst_pkg::SEQ_W-1:0]    upper_edge,
    output logic                          window_open
);

    // Control state
    swst_pkg::state_t              state_reg, state_next;
    logic [swst_pkg::CFG_W-1:0]    window_size_reg, window_size_next;
    logic [swst_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [swst_pkg::SEQ_W-1:0]    lower_reg, lower_next;
    logic [swst_pkg::SEQ_W-1:0]    current_reg, current_next;
    logic [swst_pkg::SLOT_W-1:0]   clr_idx_reg, clr_idx_next;
    logic                          rsp_valid_reg, rsp_valid_next;

    // Request and working registers
    swst_pkg::op_t                 op_reg, op_next;
    logic [swst_pkg::SEQ_W-1:0]    seq_reg, seq_next;
    logic [swst_pkg::LEN_W-1:0]    len_reg, len_next;
    logic [swst_pkg::OFF_W-1:0]    off_reg, off_next;
    logic [swst_pkg::SLOT_W-1:0]   idx_reg, idx_next;
    logic [swst_pkg::SEQ_W-1:0]    cur_seq_reg, cur_seq_next;
    logic [swst_pkg::OFF_W-1:0]    left_reg, left_next;
    swst_pkg::status_t             res_status_reg, res_status_next;
    logic                          res_found_reg, res_found_next;
    logic [swst_pkg::LEN_W-1:0]    res_len_reg, res_len_next;

    // Response register
    swst_pkg::status_t             status_reg;
    logic                          found_reg;
    logic [swst_pkg::LEN_W-1:0]    stored_length_reg;
    logic [swst_pkg::COUNT_W-1:0]  num_items_reg;
    logic [swst_pkg::SEQ_W-1:0]    lower_edge_reg;
    logic [swst_pkg::SEQ_W-1:0]    current_seq_reg;
    logic [swst_pkg::SEQ_W-1:0]    upper_edge_reg;
    logic                          window_open_reg;

    logic                          load_rsp;
    logic [swst_pkg::EFF_W-1:0]    eff;
    logic [swst_pkg::SEQ_W-1:0]    upper_calc;
    logic [swst_pkg::OFF_W-1:0]    off_clamped;
    logic [swst_pkg::SLOT_W:0]     idx_inc;
    swst_pkg::entry_t              rd_entry;
    swst_pkg::entry_t              wr_entry;

    logic                          ram_we;
    logic [swst_pkg::SLOT_W-1:0]   ram_waddr;
    logic                          ram_re;
    logic [swst_pkg::SLOT_W-1:0]   ram_raddr;
    logic [swst_pkg::ENTRY_W-1:0]  ram_rdata;

    logic                          rem_start;
    logic [swst_pkg::SEQ_W-1:0]    rem_dividend;
    swst_pkg::rem_stat_t           rem_stat;

    swst_ram #(
        .WIDTH (swst_pkg::ENTRY_W),
        .DEPTH (swst_pkg::MAX_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    swst_rem_unit u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (rem_dividend),
        .divisor  (eff),
        .stat     (rem_stat)
    );

    assign eff         = swst_pkg::eff_size(window_size_reg);
    assign upper_calc  = lower_reg + swst_pkg::SEQ_W'(eff);
    assign rd_entry    = swst_pkg::entry_t'(ram_rdata);
    assign idx_inc     = {1'b0, idx_reg} + 1'b1;
    assign off_clamped = (offset > swst_pkg::OFF_W'(swst_pkg::OFFSET_MAX)) ?
                         swst_pkg::OFF_W'(swst_pkg::OFFSET_MAX) : offset;

    always_comb
    begin
        state_next       = state_reg;
        window_size_next = window_size_reg;
        count_next       = count_reg;
        lower_next       = lower_reg;
        current_next     = current_reg;
        clr_idx_next     = clr_idx_reg;
        rsp_valid_next   = rsp_valid_reg;
        op_next          = op_reg;
        seq_next         = seq_reg;
        len_next         = len_reg;
        off_next         = off_reg;
        idx_next         = idx_reg;
        cur_seq_next     = cur_seq_reg;
        left_next        = left_reg;
        res_status_next  = res_status_reg;
        res_found_next   = res_found_reg;
        res_len_next     = res_len_reg;
        ram_we           = 1'b0;
        ram_waddr        = idx_reg;
        wr_entry         = '0;
        ram_re           = 1'b0;
        ram_raddr        = idx_reg;
        rem_start        = 1'b0;
        rem_dividend     = seq;
        load_rsp         = 1'b0;

        if (cfg_valid)
        begin
            window_size_next = cfg_data;
        end

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            swst_pkg::S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_idx_reg;
                if (clr_idx_reg == swst_pkg::SLOT_W'(swst_pkg::MAX_SLOTS - 1))
                begin
                    state_next = swst_pkg::S_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end

            swst_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next         = swst_pkg::op_t'(op);
                    seq_next        = seq;
                    len_next        = length;
                    off_next        = off_clamped;
                    res_status_next = swst_pkg::STAT_OK;
                    res_found_next  = 1'b0;
                    res_len_next    = '0;
                    unique case (swst_pkg::op_t'(op))
                        swst_pkg::OP_STORE,
                        swst_pkg::OP_DELETE,
                        swst_pkg::OP_LOOKUP:
                        begin
                            rem_start  = 1'b1;
                            state_next = swst_pkg::S_MOD;
                        end
                        swst_pkg::OP_SLIDE:
                        begin
                            rem_start    = 1'b1;
                            rem_dividend = lower_reg;
                            state_next   = swst_pkg::S_MOD;
                        end
                        swst_pkg::OP_ADVANCE:
                        begin
                            state_next = swst_pkg::S_ADVANCE;
                        end
                        default:
                        begin
                            state_next = swst_pkg::S_RESP;
                        end
                    endcase
                end
            end

            swst_pkg::S_MOD:
            begin
                if (!rem_stat.busy)
                begin
                    idx_next = rem_stat.remainder;
                    if (op_reg == swst_pkg::OP_SLIDE)
                    begin
                        cur_seq_next = lower_reg;
                        left_next    = off_reg;
                        state_next   = (off_reg == '0) ? swst_pkg::S_SLIDE_FIN
                                                       : swst_pkg::S_SLIDE_RD;
                    end
                    else
                    begin
                        state_next = swst_pkg::S_READ;
                    end
                end
            end

            swst_pkg::S_READ:
            begin
                ram_re     = 1'b1;
                state_next = swst_pkg::S_CHECK;
            end

            swst_pkg::S_CHECK:
            begin
                unique case (op_reg)
                    swst_pkg::OP_STORE:
                    begin
                        if (rd_entry.valid && rd_entry.seq != seq_reg)
                        begin
                            res_status_next = swst_pkg::STAT_CONFLICT;
                        end
                        else
                        begin
                            ram_we          = 1'b1;
                            wr_entry.valid  = 1'b1;
                            wr_entry.seq    = seq_reg;
                            wr_entry.length = len_reg;
                            if (!rd_entry.valid &&
                                count_reg < swst_pkg::COUNT_W'(swst_pkg::COUNT_MAX))
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                    end
                    swst_pkg::OP_DELETE:
                    begin
                        if (rd_entry.valid && rd_entry.seq == seq_reg)
                        begin
                            ram_we = 1'b1;
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        else
                        begin
                            res_status_next = swst_pkg::STAT_MISMATCH;
                        end
                    end
                    swst_pkg::OP_LOOKUP:
                    begin
                        if (rd_entry.valid && rd_entry.seq == seq_reg)
                        begin
                            res_found_next = 1'b1;
                            res_len_next   = rd_entry.length;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                state_next = swst_pkg::S_RESP;
            end

            swst_pkg::S_SLIDE_RD:
            begin
                ram_re     = 1'b1;
                state_next = swst_pkg::S_SLIDE_CHK;
            end

            swst_pkg::S_SLIDE_CHK:
            begin
                // Clear the slot only if it still holds the sequence number being passed.
                if (rd_entry.valid && rd_entry.seq == cur_seq_reg)
                begin
                    ram_we = 1'b1;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                cur_seq_next = cur_seq_reg + 1'b1;
                left_next    = left_reg - 1'b1;
                if (idx_inc == (swst_pkg::SLOT_W + 1)'(eff))
                begin
                    idx_next = '0;
                end
                else
                begin
                    idx_next = idx_inc[swst_pkg::SLOT_W-1:0];
                end
                state_next = (left_reg == swst_pkg::OFF_W'(1)) ? swst_pkg::S_SLIDE_FIN
                                                               : swst_pkg::S_SLIDE_RD;
            end

            swst_pkg::S_SLIDE_FIN:
            begin
                // The cursor has reached lower plus offset, the new lower edge.
                lower_next = cur_seq_reg;
                if (swst_pkg::serial_below(current_reg, cur_seq_reg))
                begin
                    current_next = cur_seq_reg;
                end
                state_next = swst_pkg::S_RESP;
            end

            swst_pkg::S_ADVANCE:
            begin
                current_next = current_reg + swst_pkg::SEQ_W'(off_reg);
                state_next   = swst_pkg::S_RESP;
            end

            swst_pkg::S_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    load_rsp       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = swst_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = swst_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= swst_pkg::S_CLEAR;
            window_size_reg <= swst_pkg::CFG_W'(swst_pkg::WS_RESET);
            count_reg       <= '0;
            lower_reg       <= '0;
            current_reg     <= '0;
            clr_idx_reg     <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            window_size_reg <= window_size_next;
            count_reg       <= count_next;
            lower_reg       <= lower_next;
            current_reg     <= current_next;
            clr_idx_reg     <= clr_idx_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        seq_reg        <= seq_next;
        len_reg        <= len_next;
        off_reg        <= off_next;
        idx_reg        <= idx_next;
        cur_seq_reg    <= cur_seq_next;
        left_reg       <= left_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_len_reg    <= res_len_next;
        if (load_rsp)
        begin
            status_reg        <= res_status_reg;
            found_reg         <= res_found_reg;
            stored_length_reg <= res_len_reg;
            num_items_reg     <= count_reg;
            lower_edge_reg    <= lower_reg;
            current_seq_reg   <= current_reg;
            upper_edge_reg    <= upper_calc;
            window_open_reg   <= swst_pkg::serial_below(current_reg, upper_calc);
        end
    end

    assign cfg_ready     = 1'b1;
    assign req_stall     = (state_reg != swst_pkg::S_IDLE);
    assign rsp_valid     = rsp_valid_reg;
    assign status        = status_reg;
    assign found         = found_reg;
    assign stored_length = stored_length_reg;
    assign num_items     = num_items_reg;
    assign lower_edge    = lower_edge_reg;
    assign current_seq   = current_seq_reg;
    assign upper_edge    = upper_edge_reg;
    assign window_open   = window_open_reg;

endmodule

@@ design/swst_checker.sv @@
// ----------------------------------------------------------------------------
// Sliding window slot tracker checker
// Port-level checks on the response channel and the request handshake.
// ----------------------------------------------------------------------------
`include "sliding_window_slot_tracker_assert.svh"

module swst_assert_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_stall,
    input  logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  logic [1:0]                    status,
    input  logic [swst_pkg::COUNT_W-1:0]  num_items,
    input  logic [swst_pkg::SEQ_W-1:0]    current_seq,
    input  logic [swst_pkg::SEQ_W-1:0]    upper_edge,
    input  logic                          window_open
);

    // A stalled response word stays on the channel.
    `SWST_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)

    // The block is busy in the cycle after it takes a request.
    `SWST_ASSERT_NEXT(a_busy_after_take, req_valid && !req_stall, req_stall)

    // The open flag agrees with the serial order of current and upper edge.
    `SWST_ASSERT_SAME(a_open_flag, rsp_valid, window_open == swst_pkg::serial_below(current_seq, upper_edge))

    // The item count never passes its limit and no unused status code appears.
    `SWST_ASSERT_SAME(a_count_status, rsp_valid, (num_items <= swst_pkg::COUNT_W'(swst_pkg::COUNT_MAX)) && (status <= swst_pkg::STAT_MISMATCH))

endmodule

bind sliding_window_slot_tracker swst_assert_checker u_swst_checker (.*);
